FILE: design/assert_macros.svh
// assertion macros used by the top-level design file
// both macros sample on clk and are disabled while rst_n is low
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: design/itoa_pkg.sv
// ----------------------------------------------------------------------------
// itoa_pkg
// Shared types and constants for the integer to decimal text converter.
// ----------------------------------------------------------------------------
package itoa_pkg;

  // ascii codes, six bits wide
  localparam logic [5:0] ASCII_MINUS = 6'd45;
  localparam logic [5:0] ASCII_ZERO  = 6'd48;
  localparam logic [5:0] ASCII_NINE  = 6'd57;

  // bcd digit width
  localparam int DIGIT_W = 4;

  // commands from controller to datapath
  typedef struct packed {
    logic load;        // capture input word and clear bcd
    logic shift;       // one double-dabble step
    logic emit_sign;   // put '-' out if the word is negative
    logic set_idx;     // point at the leading nonzero digit
    logic emit_digit;  // put the current digit out and step down
  } itoa_cmd_t;

  // status from datapath to controller
  typedef struct packed {
    logic idx_zero;    // current digit is the least significant one
  } itoa_stat_t;

endpackage

FILE: design/int_to_decimal_ascii_top.sv
// ----------------------------------------------------------------------------
// int_to_decimal_ascii_top
// Signed integer to decimal ascii text, one character per output word.
// ----------------------------------------------------------------------------
// A value is taken when start is high and busy is low. Its text leaves most
// significant character first, one word per out_valid pulse, with a leading
// '-' for negative values and out_last on the final digit. The receiver
// cannot stall: each word is on the outputs for exactly one cycle. The
// conversion is a bit-serial shift-add-3 loop over the VALUE_BITS input
// bits (the '-' is issued in its first step), then a search for the leading
// digit, then the digits in turn. busy stays high through all three, and the
// next value can be taken in the cycle its last digit is shown.
module int_to_decimal_ascii_top #(
  parameter int VALUE_BITS = 32
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         start,
  output logic                         busy,
  input  logic signed [VALUE_BITS-1:0] in_value,
  output logic                         out_valid,
  output logic [5:0]                   out_ascii_char,
  output logic                         out_last
);
  import itoa_pkg::*;

  `include "assert_macros.svh"

  itoa_cmd_t  cmd;
  itoa_stat_t stat;
  logic       char_ok;

  // sequencer
  itoa_ctrl #(
    .VALUE_BITS (VALUE_BITS)
  ) u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .busy  (busy),
    .cmd   (cmd),
    .stat  (stat)
  );

  // conversion datapath
  itoa_dp #(
    .VALUE_BITS (VALUE_BITS)
  ) u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_value       (in_value),
    .cmd            (cmd),
    .stat           (stat),
    .out_valid      (out_valid),
    .out_ascii_char (out_ascii_char),
    .out_last       (out_last)
  );

  // minus sign or a decimal digit
  assign char_ok = (out_ascii_char == ASCII_MINUS) ||
                   ((out_ascii_char >= ASCII_ZERO) && (out_ascii_char <= ASCII_NINE));

  // checks
  `ASSERT_NEXT(a_accept_busy, start && !busy, busy, "accepted word did not raise busy")
  `ASSERT_IMP(a_last_frees, out_valid && out_last, !busy, "busy after the final digit")
  `ASSERT_IMP(a_more_busy, out_valid && !out_last, busy, "idle while characters remain")
  `ASSERT_IMP(a_char_code, out_valid, char_ok, "bad character code")

endmodule

FILE: design/itoa_ctrl.sv
// ----------------------------------------------------------------------------
// itoa_ctrl
// Sequencer: bit-serial bcd conversion, leading digit search, digit output.
// ----------------------------------------------------------------------------
module itoa_ctrl #(
  parameter int VALUE_BITS = 32
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  output logic                busy,
  output itoa_pkg::itoa_cmd_t cmd,
  input  itoa_pkg::itoa_stat_t stat
);
  import itoa_pkg::*;

  localparam int CNT_W = $clog2(VALUE_BITS);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CONV,
    ST_FIND,
    ST_EMIT
  } state_t;

  state_t             state_r, state_nxt;
  logic [CNT_W-1:0]   cnt_r, cnt_nxt;

  // next state and commands
  always_comb begin
    state_nxt      = state_r;
    cnt_nxt        = cnt_r;
    cmd            = '0;
    case (state_r)
      ST_IDLE: begin
        if (start) begin
          cmd.load  = 1'b1;
          cnt_nxt   = '0;
          state_nxt = ST_CONV;
        end
      end
      ST_CONV: begin
        cmd.shift     = 1'b1;
        cmd.emit_sign = (cnt_r == '0);
        cnt_nxt       = cnt_r + 1'b1;
        if (cnt_r == CNT_W'(VALUE_BITS - 1)) begin
          state_nxt = ST_FIND;
        end
      end
      ST_FIND: begin
        cmd.set_idx = 1'b1;
        state_nxt   = ST_EMIT;
      end
      ST_EMIT: begin
        cmd.emit_digit = 1'b1;
        if (stat.idx_zero) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // state and bit counter
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

  assign busy = (state_r != ST_IDLE);

endmodule

FILE: design/itoa_dp.sv
// ----------------------------------------------------------------------------
// itoa_dp
// Datapath: magnitude, shift-add-3 bcd register, digit pointer, output word.
// ----------------------------------------------------------------------------
module itoa_dp #(
  parameter int VALUE_BITS = 32
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic signed [VALUE_BITS-1:0] in_value,
  input  itoa_pkg::itoa_cmd_t     cmd,
  output itoa_pkg::itoa_stat_t    stat,
  output logic                    out_valid,
  output logic [5:0]              out_ascii_char,
  output logic                    out_last
);
  import itoa_pkg::*;

  // digits in the largest magnitude, 2**(VALUE_BITS-1)
  localparam int NDIG  = ((VALUE_BITS - 1) * 30103) / 100000 + 1;
  localparam int IDX_W = $clog2(NDIG);

  logic [VALUE_BITS-1:0] mag_r, mag_nxt;
  logic [DIGIT_W-1:0]    bcd_r   [NDIG];
  logic [DIGIT_W-1:0]    bcd_nxt [NDIG];
  logic [DIGIT_W-1:0]    adj     [NDIG];
  logic                  neg_r, neg_nxt;
  logic [IDX_W-1:0]      idx_r, idx_nxt, lead_idx;
  logic [VALUE_BITS-1:0] raw_u;
  logic                  valid_r, valid_nxt;
  logic [5:0]            char_r, char_nxt;
  logic                  last_r, last_nxt;

  assign raw_u = in_value;

  // add 3 to every digit of 5 or more
  always_comb begin
    for (int i = 0; i < NDIG; i++) begin
      adj[i] = (bcd_r[i] >= DIGIT_W'(5)) ? bcd_r[i] + DIGIT_W'(3) : bcd_r[i];
    end
  end

  // leading nonzero digit, zero when the whole value is zero
  always_comb begin
    lead_idx = '0;
    for (int i = 0; i < NDIG; i++) begin
      if (bcd_r[i] != '0) begin
        lead_idx = IDX_W'(i);
      end
    end
  end

  // datapath next values
  always_comb begin
    mag_nxt   = mag_r;
    bcd_nxt   = bcd_r;
    neg_nxt   = neg_r;
    idx_nxt   = idx_r;
    valid_nxt = 1'b0;
    char_nxt  = char_r;
    last_nxt  = last_r;
    if (cmd.load) begin
      neg_nxt = raw_u[VALUE_BITS-1];
      mag_nxt = raw_u[VALUE_BITS-1] ? (~raw_u + 1'b1) : raw_u;
      for (int i = 0; i < NDIG; i++) begin
        bcd_nxt[i] = '0;
      end
    end
    if (cmd.shift) begin
      mag_nxt = {mag_r[VALUE_BITS-2:0], 1'b0};
      bcd_nxt[0] = {adj[0][DIGIT_W-2:0], mag_r[VALUE_BITS-1]};
      for (int i = 1; i < NDIG; i++) begin
        bcd_nxt[i] = {adj[i][DIGIT_W-2:0], adj[i-1][DIGIT_W-1]};
      end
    end
    if (cmd.emit_sign && neg_r) begin
      valid_nxt = 1'b1;
      char_nxt  = ASCII_MINUS;
      last_nxt  = 1'b0;
    end
    if (cmd.set_idx) begin
      idx_nxt = lead_idx;
    end
    if (cmd.emit_digit) begin
      valid_nxt = 1'b1;
      char_nxt  = ASCII_ZERO + {2'b00, bcd_r[idx_r]};
      last_nxt  = (idx_r == '0);
      idx_nxt   = idx_r - 1'b1;
    end
  end

  // strobe needs reset, payload does not
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    mag_r  <= mag_nxt;
    bcd_r  <= bcd_nxt;
    neg_r  <= neg_nxt;
    idx_r  <= idx_nxt;
    char_r <= char_nxt;
    last_r <= last_nxt;
  end

  assign stat.idx_zero  = (idx_r == '0);
  assign out_valid      = valid_r;
  assign out_ascii_char = char_r;
  assign out_last       = last_r;

endmodule

FILE: tb/sv/tb.sv
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the signed integer to decimal ascii converter.
// A directed table covers zero, single digits, power-of-ten boundaries and
// both extremes, then random values of every text length follow, sent with
// and without gaps on the start side. Each output word is compared, char
// and last flag, against a queue filled from a row's typed text or by a behavioral converter.
// ----------------------------------------------------------------------------
module tb;
  import itoa_pkg::*;

  localparam int VALUE_BITS   = 32;
  localparam int RADIX        = 10;
  localparam int MAX_CHARS    = 11;
  localparam int RANDOM_ITEMS = 280;
  localparam int QUIET_LIMIT  = 1000;
  localparam int DRAIN_CYCLES = VALUE_BITS + 16;
  localparam int MAX_REPORTS  = 10;
  localparam int N_DIRECTED   = 24;

  // one expected output word
  typedef struct {
    logic [5:0] ascii_char;
    logic       last;
  } text_word_t;

  // directed row: empty text means the converter model supplies the words
  typedef struct {
    logic [VALUE_BITS-1:0] value;
    string                 text;
  } text_case_t;

  logic                         clk = 1'b0;
  logic                         rst_n;
  logic                         start;
  logic                         busy;
  logic signed [VALUE_BITS-1:0] in_value;
  logic                         out_valid;
  logic [5:0]                   out_ascii_char;
  logic                         out_last;

  text_word_t expected_text_q[$];
  int         char_errors;
  int         chars_checked;
  int         values_sent;
  int         negatives_sent;
  int         idle_pct;
  bit [MAX_CHARS:0] lengths_seen;

  text_case_t directed_cases [N_DIRECTED] = '{
    '{32'd0,           "0"},
    '{32'd1,           "1"},
    '{-32'sd1,         "-1"},
    '{32'd9,           "9"},
    '{-32'sd9,         "-9"},
    '{32'd10,          "10"},
    '{-32'sd10,        "-10"},
    '{32'd99,          "99"},
    '{32'd100,         "100"},
    '{32'd12345,       "12345"},
    '{32'd999999999,   "999999999"},
    '{-32'sd999999999, "-999999999"},
    '{32'd1000000000,  "1000000000"},
    '{32'd1234567890,  "1234567890"},
    '{32'h7FFF_FFFF,   "2147483647"},
    '{32'h8000_0000,   "-2147483648"},
    '{32'h8000_0001,   "-2147483647"},
    '{32'h7FFF_FFFE,   ""},
    '{32'h5555_5555,   ""},
    '{32'hAAAA_AAAA,   ""},
    '{32'h0F0F_0F0F,   ""},
    '{32'hF0F0_F0F0,   ""},
    '{32'h0000_FFFF,   ""},
    '{32'hFFFF_0000,   ""}
  };

  int_to_decimal_ascii_top #(
    .VALUE_BITS(VALUE_BITS)
  ) u_top (
    .clk           (clk),
    .rst_n         (rst_n),
    .start         (start),
    .busy          (busy),
    .in_value      (in_value),
    .out_valid     (out_valid),
    .out_ascii_char(out_ascii_char),
    .out_last      (out_last)
  );

  // clock, period 10
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // expected text of one value: optional '-' then digits, msd first
  function automatic void predict_text(input logic [VALUE_BITS-1:0] v);
    logic [VALUE_BITS-1:0] mag;
    logic [3:0]            digits[$];
    text_word_t            w;
    int                    n;
    n = 0;
    mag = v[VALUE_BITS-1] ? -v : v;
    do begin
      digits.push_front(4'(mag % RADIX));
      mag = mag / RADIX;
    end while (mag != 0);
    if (v[VALUE_BITS-1]) begin
      w.ascii_char = ASCII_MINUS;
      w.last = 1'b0;
      expected_text_q.push_back(w);
      n++;
    end
    foreach (digits[i]) begin
      w.ascii_char = ASCII_ZERO + 6'(digits[i]);
      w.last = (i == digits.size() - 1);
      expected_text_q.push_back(w);
      n++;
    end
    lengths_seen[n] = 1'b1;
  endfunction

  // expected words read straight from a typed string
  function automatic void push_typed_text(input string text);
    text_word_t w;
    byte        c;
    for (int i = 0; i < text.len(); i++) begin
      c = text[i];
      w.ascii_char = c[5:0];
      w.last = (i == text.len() - 1);
      expected_text_q.push_back(w);
    end
    lengths_seen[text.len()] = 1'b1;
  endfunction

  // random value with an even spread over text lengths and boundaries
  function automatic logic [VALUE_BITS-1:0] pick_value();
    longint lo;
    longint hi;
    longint mag;
    int     kind;
    int     nd;
    kind = $urandom_range(9);
    mag = 0;
    if (kind <= 5) begin
      nd = $urandom_range(1, 10);
      lo = 1;
      repeat (nd - 1) lo = lo * RADIX;
      hi = lo * RADIX - 1;
      if (nd == 1) lo = 0;
      if (hi > 64'sd2147483647) hi = 64'sd2147483647;
      mag = lo + longint'($urandom) % (hi - lo + 1);
    end else if (kind <= 7) begin
      return $urandom;
    end else if (kind == 8) begin
      // around a power of ten
      mag = 1;
      repeat ($urandom_range(0, 9)) mag = mag * RADIX;
      mag = mag + $urandom_range(0, 2) - 1;
    end else begin
      // next to the extremes
      if ($urandom_range(1)) return 32'h7FFF_FFFF - $urandom_range(3);
      return 32'h8000_0000 + $urandom_range(3);
    end
    return $urandom_range(1) ? VALUE_BITS'(-mag) : VALUE_BITS'(mag);
  endfunction

  // drive one value, hold start until taken, then queue its text
  task automatic send_value(input logic [VALUE_BITS-1:0] v, input string text);
    int gap;
    gap = ($urandom_range(99) < idle_pct) ? $urandom_range(1, 60) : 0;
    repeat (gap) begin
      @(negedge clk);
      start <= 1'b0;
      in_value <= $urandom;
    end
    @(negedge clk);
    start <= 1'b1;
    in_value <= v;
    do @(posedge clk); while (busy);
    if (text.len() != 0) push_typed_text(text);
    else predict_text(v);
    values_sent++;
    if (v[VALUE_BITS-1]) negatives_sent++;
  endtask

  // output word checker, sampled at the rising edge
  always @(posedge clk) begin
    if (rst_n && out_valid) begin
      if (expected_text_q.size() == 0) begin
        char_errors++;
        if (char_errors <= MAX_REPORTS)
          $display("error: unexpected word char=%0d last=%0d", out_ascii_char, out_last);
      end else begin
        text_word_t w;
        w = expected_text_q.pop_front();
        chars_checked++;
        if (out_ascii_char !== w.ascii_char || out_last !== w.last) begin
          char_errors++;
          if (char_errors <= MAX_REPORTS)
            $display("error: word %0d expected char=%0d last=%0d, got char=%0d last=%0d",
                     chars_checked, w.ascii_char, w.last, out_ascii_char, out_last);
        end
      end
    end
  end

  // watchdog on cycles with no handshake on either side
  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < QUIET_LIMIT) begin
      @(posedge clk);
      if ((start && !busy) || out_valid) quiet = 0;
      else quiet++;
    end
    $display("timeout: no word moved for %0d cycles", QUIET_LIMIT);
    $display("FAILED: results differ");
    $finish;
  end

  // stimulus
  initial begin : stimulus
    int phase_pct [4] = '{0, 46, 0, 17};
    rst_n = 1'b0;
    start = 1'b0;
    in_value = '0;
    char_errors = 0;
    chars_checked = 0;
    values_sent = 0;
    negatives_sent = 0;
    lengths_seen = '0;
    idle_pct = 0;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // directed table
    foreach (directed_cases[i])
      send_value(directed_cases[i].value, directed_cases[i].text);

    // random values over the idle phases
    foreach (phase_pct[p]) begin
      idle_pct = phase_pct[p];
      repeat (RANDOM_ITEMS / 4) send_value(pick_value(), "");
    end

    @(negedge clk);
    start <= 1'b0;
    while (expected_text_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("converted %0d values (%0d negative), %0d words checked",
             values_sent, negatives_sent, chars_checked);
    $display("text lengths seen (bit n = n chars): %b", lengths_seen);
    if (char_errors == 0 && expected_text_q.size() == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("%0d word errors, %0d words still expected",
               char_errors, expected_text_q.size());
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule
